// ----- rtl/core/mtq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtq_pkg
// shared types and constants of the multi-timer queue
// ----------------------------------------------------------------------------
package mtq_pkg;

  localparam int MAX_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_TIMERS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 40;
  localparam int US_PER_SEC  = 1000000;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_RESCHED = 3'd1;
  localparam logic [2:0] ST_CANCEL  = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;

  typedef struct packed {
    logic        action;
    logic [7:0]  timer_id;
    logic [19:0] seconds;
    logic [19:0] microseconds;
    logic [31:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic       table_full;
    logic [7:0] expired_id;
    logic       last;
  } out_word_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic              is_tick;
    logic [7:0]        timer_id;
    logic [TIME_W-1:0] sec_us;
    logic [19:0]       usecs;
    logic [31:0]       elapsed;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_INSERT,
    S_RESULT,
    S_TSUB,
    S_POP
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/mtq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtq_front
// input stage: takes words, scales seconds to microseconds, classifies
// ----------------------------------------------------------------------------
module mtq_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mtq_pkg::in_word_t in_word,
  output logic                  cmd_valid,
  input  wire logic             cmd_full,
  output mtq_pkg::cmd_t         cmd
);

  logic          fv_r, fv_nxt;
  mtq_pkg::cmd_t cmd_r, cmd_nxt;
  logic          take;

  assign in_stall  = fv_r && cmd_full;
  assign take      = in_valid && !in_stall;
  assign cmd_valid = fv_r;
  assign cmd       = cmd_r;

  always_comb begin
    fv_nxt  = (fv_r && cmd_full) || take;
    cmd_nxt = cmd_r;
    if (take) begin
      cmd_nxt.is_tick  = in_word.action;
      cmd_nxt.timer_id = in_word.timer_id;
      cmd_nxt.sec_us   = mtq_pkg::TIME_W'(in_word.seconds) *
                         mtq_pkg::TIME_W'(mtq_pkg::US_PER_SEC);
      cmd_nxt.usecs    = in_word.microseconds;
      cmd_nxt.elapsed  = in_word.elapsed_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/mtq_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtq_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module mtq_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mtq_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output mtq_pkg::cmd_t      head
);

  localparam int PW = $clog2(mtq_pkg::FIFO_DEPTH);

  mtq_pkg::cmd_t mem_r [mtq_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = cnt_r == (PW+1)'(mtq_pkg::FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mtq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtq_back
// sorted timer table as a row of cells, with the sequencer that runs
// set and tick commands and drives the result register
// ----------------------------------------------------------------------------
module mtq_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_avail,
  input  wire mtq_pkg::cmd_t cmd_head,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mtq_pkg::out_word_t out_word
);

  localparam int N  = mtq_pkg::MAX_TIMERS;
  localparam int TW = mtq_pkg::TIME_W;
  localparam int CW = mtq_pkg::CNT_W;
  localparam int RW = mtq_pkg::RES_W;

  mtq_pkg::state_t     state_r, state_nxt;
  logic [7:0]          id_r  [N];
  logic [7:0]          id_nxt[N];
  logic [TW-1:0]       rem_r  [N];
  logic [TW-1:0]       rem_nxt[N];
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lim_r, lim_nxt;
  logic [RW-1:0]       npop_r, npop_nxt;
  logic [TW-1:0]       t_r, t_nxt;
  logic [7:0]          cid_r, cid_nxt;
  logic [31:0]         el_r, el_nxt;
  logic [2:0]          rs_r, rs_nxt;
  logic                rf_r, rf_nxt;
  logic                ov_r, ov_nxt;
  mtq_pkg::out_word_t  ow_r, ow_nxt;

  logic [N-1:0]        match;
  logic [N-1:0]        ahead;
  logic [CW-1:0]       midx;
  logic                any_match, t_zero, out_free, pop_ok, more_after;

  assign out_valid = ov_r;
  assign out_word  = ow_r;
  assign out_free  = !ov_r || !out_stall;
  assign t_zero    = t_r == '0;
  assign any_match = |match;
  assign pop_ok    = (count_r != '0) && (rem_r[0] == '0) &&
                     (npop_r < RW'(mtq_pkg::MAX_RESULTS));
  assign more_after = (count_r > CW'(1)) && (rem_r[1] == '0) &&
                      (npop_r + RW'(1) < RW'(mtq_pkg::MAX_RESULTS));

  // per-cell compares
  always_comb begin
    midx = '0;
    for (int j = 0; j < N; j++) begin
      match[j] = (CW'(j) < count_r) && (id_r[j] == cid_r);
      ahead[j] = (CW'(j) >= count_r) || (rem_r[j] > t_r) ||
                 ((rem_r[j] == t_r) && (CW'(j) >= lim_r));
      if (match[j]) begin
        midx = midx | CW'(j);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtq_pkg::S_IDLE: begin
        if (cmd_avail) begin
          state_nxt = cmd_head.is_tick ? mtq_pkg::S_TSUB : mtq_pkg::S_FIND;
        end
      end
      mtq_pkg::S_FIND: begin
        if (t_zero || (!any_match && count_r == CW'(N))) begin
          state_nxt = mtq_pkg::S_RESULT;
        end else begin
          state_nxt = mtq_pkg::S_INSERT;
        end
      end
      mtq_pkg::S_INSERT: state_nxt = mtq_pkg::S_RESULT;
      mtq_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = mtq_pkg::S_IDLE;
        end
      end
      mtq_pkg::S_TSUB:   state_nxt = mtq_pkg::S_POP;
      mtq_pkg::S_POP: begin
        if (out_free && !(pop_ok && more_after)) begin
          state_nxt = mtq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mtq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    id_nxt    = id_r;
    rem_nxt   = rem_r;
    count_nxt = count_r;
    lim_nxt   = lim_r;
    npop_nxt  = npop_r;
    t_nxt     = t_r;
    cid_nxt   = cid_r;
    el_nxt    = el_r;
    rs_nxt    = rs_r;
    rf_nxt    = rf_r;
    cmd_pop   = 1'b0;
    ov_nxt    = ov_r && out_stall;
    ow_nxt    = ow_r;
    unique case (state_r)
      mtq_pkg::S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop  = 1'b1;
          cid_nxt  = cmd_head.timer_id;
          el_nxt   = cmd_head.elapsed;
          t_nxt    = cmd_head.sec_us + TW'(cmd_head.usecs);
          npop_nxt = '0;
        end
      end
      mtq_pkg::S_FIND: begin
        rf_nxt = 1'b0;
        if (any_match) begin
          // close the gap left by the matched cell
          for (int j = 0; j < N - 1; j++) begin
            if (CW'(j) >= midx) begin
              id_nxt[j]  = id_r[j+1];
              rem_nxt[j] = rem_r[j+1];
            end
          end
          count_nxt = count_r - CW'(1);
          lim_nxt   = midx;
          rs_nxt    = t_zero ? mtq_pkg::ST_CANCEL : mtq_pkg::ST_RESCHED;
        end else begin
          lim_nxt = CW'(N);
          if (t_zero) begin
            rs_nxt = mtq_pkg::ST_IGNORED;
          end else begin
            rs_nxt = mtq_pkg::ST_ADDED;
            rf_nxt = count_r == CW'(N);
          end
        end
      end
      mtq_pkg::S_INSERT: begin
        if (ahead[0]) begin
          id_nxt[0]  = cid_r;
          rem_nxt[0] = t_r;
        end
        for (int j = 1; j < N; j++) begin
          if (ahead[j]) begin
            if (!ahead[j-1]) begin
              id_nxt[j]  = cid_r;
              rem_nxt[j] = t_r;
            end else begin
              id_nxt[j]  = id_r[j-1];
              rem_nxt[j] = rem_r[j-1];
            end
          end
        end
        count_nxt = count_r + CW'(1);
      end
      mtq_pkg::S_RESULT: begin
        if (out_free) begin
          ov_nxt            = 1'b1;
          ow_nxt.status     = rs_r;
          ow_nxt.table_full = rf_r;
          ow_nxt.expired_id = '0;
          ow_nxt.last       = 1'b1;
        end
      end
      mtq_pkg::S_TSUB: begin
        for (int j = 0; j < N; j++) begin
          rem_nxt[j] = (rem_r[j] > TW'(el_r)) ? rem_r[j] - TW'(el_r) : '0;
        end
      end
      mtq_pkg::S_POP: begin
        if (out_free) begin
          ov_nxt            = 1'b1;
          ow_nxt.table_full = 1'b0;
          if (pop_ok) begin
            ow_nxt.status     = mtq_pkg::ST_EXPIRED;
            ow_nxt.expired_id = id_r[0];
            ow_nxt.last       = !more_after;
            for (int j = 0; j < N - 1; j++) begin
              id_nxt[j]  = id_r[j+1];
              rem_nxt[j] = rem_r[j+1];
            end
            count_nxt = count_r - CW'(1);
            npop_nxt  = npop_r + RW'(1);
          end else begin
            ow_nxt.status     = mtq_pkg::ST_NONE;
            ow_nxt.expired_id = '0;
            ow_nxt.last       = 1'b1;
          end
        end
      end
      default: begin
        ov_nxt = ov_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtq_pkg::S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    id_r   <= id_nxt;
    rem_r  <= rem_nxt;
    lim_r  <= lim_nxt;
    npop_r <= npop_nxt;
    t_r    <= t_nxt;
    cid_r  <= cid_nxt;
    el_r   <= el_nxt;
    rs_r   <= rs_nxt;
    rf_r   <= rf_nxt;
    ow_r   <= ow_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/multi_timer_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_timer_queue
// ordered table of one-shot timers driven by set and tick words
// ----------------------------------------------------------------------------
// a set word runs through load, search, insert and result steps in the back end,
// and through load, search and result when nothing is inserted (cancel, ignored
// zero, table full); a tick word runs through load and subtract and then pops one
// result word at a time, waiting while the output is stalled, the table being a
// row of 16 cells that all compare, subtract or shift in the same cycle.
// the front end scales seconds in its own register and a two-deep command
// queue lets it take new words while the back end works, and results wait
// in an output register so the next command can start under a stalled out.
// timer entries are undefined after reset; only the entry count is cleared.
module multi_timer_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mtq_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mtq_pkg::out_word_t      out_word
);

  // front to queue
  logic          f_valid;
  logic          q_full;
  mtq_pkg::cmd_t f_cmd;
  // queue to back
  logic          q_avail;
  logic          q_pop;
  mtq_pkg::cmd_t q_head;

  mtq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cmd_valid(f_valid),
    .cmd_full (q_full),
    .cmd      (f_cmd)
  );

  mtq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_avail),
    .head     (q_head)
  );

  mtq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_avail(q_avail),
    .cmd_head (q_head),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

// ----- rtl/core/mtq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtq_checker
// port-level checks of the timer queue result channel
// ----------------------------------------------------------------------------
module mtq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mtq_pkg::out_word_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == mtq_pkg::ST_NONE |-> out_word.last)
    else $error("empty tick result not last");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != mtq_pkg::ST_EXPIRED |-> out_word.expired_id == '0)
    else $error("id on non-expiry result");

  a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.table_full |-> out_word.status == mtq_pkg::ST_ADDED &&
    out_word.last)
    else $error("full flag on wrong result");

endmodule

bind multi_timer_queue mtq_checker u_mtq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
`default_nettype wire

// ----- tb/multi_timer_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_queue_tb
// drives set and tick words into the timer queue with random bursts and
// output stalls, predicts every result word and checks them in order
// ----------------------------------------------------------------------------
module multi_timer_queue_tb;

  // scoreboard: keeps its own ordered timer table and the queue of expected
  // result words that each accepted input word produces
  class timer_scoreboard;
    logic [7:0]                 tbl_id [mtq_pkg::MAX_TIMERS];
    logic [mtq_pkg::TIME_W-1:0] tbl_us [mtq_pkg::MAX_TIMERS];
    int                         n_entries;
    mtq_pkg::out_word_t         pending [$];
    int                         n_errors;
    int                         n_checked;
    int                         n_expired;
    int                         n_full;

    function void clear();
      n_entries = 0;
      pending.delete();
    endfunction

    function void push(logic [2:0] st, logic full, logic [7:0] id, logic lst);
      mtq_pkg::out_word_t w;
      w.status = st;
      w.table_full = full;
      w.expired_id = id;
      w.last = lst;
      pending.push_back(w);
    endfunction

    function void drop_at(int pos);
      for (int i = pos; i + 1 < n_entries; i++) begin
        tbl_id[i] = tbl_id[i + 1];
        tbl_us[i] = tbl_us[i + 1];
      end
      n_entries--;
    endfunction

    // stable insertion sort by remaining time
    function void sort_table();
      logic [mtq_pkg::TIME_W-1:0] t;
      logic [7:0]                 d;
      int                         j;
      for (int i = 1; i < n_entries; i++) begin
        t = tbl_us[i];
        d = tbl_id[i];
        j = i;
        while (j > 0 && tbl_us[j - 1] > t) begin
          tbl_us[j] = tbl_us[j - 1];
          tbl_id[j] = tbl_id[j - 1];
          j--;
        end
        tbl_us[j] = t;
        tbl_id[j] = d;
      end
    endfunction

    function void note_input(mtq_pkg::in_word_t w);
      logic [mtq_pkg::TIME_W-1:0] t;
      int                         n;
      if (!w.action) begin
        t = mtq_pkg::TIME_W'(w.seconds) * mtq_pkg::TIME_W'(mtq_pkg::US_PER_SEC) +
            mtq_pkg::TIME_W'(w.microseconds);
        for (int i = 0; i < n_entries; i++) begin
          if (tbl_id[i] == w.timer_id) begin
            if (t == 0) begin
              drop_at(i);
              push(mtq_pkg::ST_CANCEL, 1'b0, 8'd0, 1'b1);
            end else begin
              tbl_us[i] = t;
              sort_table();
              push(mtq_pkg::ST_RESCHED, 1'b0, 8'd0, 1'b1);
            end
            return;
          end
        end
        if (t == 0) begin
          push(mtq_pkg::ST_IGNORED, 1'b0, 8'd0, 1'b1);
        end else if (n_entries >= mtq_pkg::MAX_TIMERS) begin
          n_full++;
          push(mtq_pkg::ST_ADDED, 1'b1, 8'd0, 1'b1);
        end else begin
          tbl_id[n_entries] = w.timer_id;
          tbl_us[n_entries] = t;
          n_entries++;
          sort_table();
          push(mtq_pkg::ST_ADDED, 1'b0, 8'd0, 1'b1);
        end
        return;
      end
      for (int i = 0; i < n_entries; i++)
        tbl_us[i] = (tbl_us[i] > mtq_pkg::TIME_W'(w.elapsed_us)) ?
                    tbl_us[i] - mtq_pkg::TIME_W'(w.elapsed_us) : '0;
      n = 0;
      while (n_entries > 0 && tbl_us[0] == 0 && n < mtq_pkg::MAX_RESULTS) begin
        push(mtq_pkg::ST_EXPIRED, 1'b0, tbl_id[0], 1'b0);
        drop_at(0);
        n++;
      end
      n_expired += n;
      if (n == 0) push(mtq_pkg::ST_NONE, 1'b0, 8'd0, 1'b1);
      else pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(mtq_pkg::out_word_t got);
      mtq_pkg::out_word_t exp_w;
      n_checked++;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.status !== exp_w.status || got.table_full !== exp_w.table_full ||
          got.expired_id !== exp_w.expired_id || got.last !== exp_w.last) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: exp st=%0d full=%0d id=%0d last=%0d, %s",
                   exp_w.status, exp_w.table_full, exp_w.expired_id, exp_w.last,
                   $sformatf("got st=%0d full=%0d id=%0d last=%0d",
                             got.status, got.table_full, got.expired_id, got.last));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mtq_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  mtq_pkg::out_word_t out_word;

  timer_scoreboard sb;
  int        n_sent;
  bit        stall_on;   // receiver stall pattern enable

  multi_timer_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each accepted word, stall in runs of its own
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(0, 99) < 60);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // sends one word and waits for its acceptance; the scoreboard sees it at
  // the accepting edge
  task automatic send_word(mtq_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    n_sent++;
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic mtq_pkg::in_word_t set_word(logic [7:0] id, logic [19:0] s,
                                                 logic [19:0] us);
    mtq_pkg::in_word_t w;
    w = '0;
    w.timer_id = id;
    w.seconds = s;
    w.microseconds = us;
    w.elapsed_us = $urandom();   // unused by set, toggles anyway
    return w;
  endfunction

  function automatic mtq_pkg::in_word_t tick_word(logic [31:0] el);
    mtq_pkg::in_word_t w;
    w = '0;
    w.action = 1'b1;
    w.elapsed_us = el;
    w.timer_id = 8'($urandom());
    w.seconds = 20'($urandom());
    w.microseconds = 20'($urandom());
    return w;
  endfunction

  // random word: mostly short timers on a small id pool so that timers get
  // rescheduled, cancelled and expire; sometimes wide values and noise
  function automatic mtq_pkg::in_word_t rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      return tick_word($urandom_range(0, 99) < 80 ? $urandom_range(0, 3000) : $urandom());
    if (pick < 45)
      return set_word(8'($urandom_range(0, 23)), 20'd0, 20'd0);
    if (pick < 85)
      return set_word(8'($urandom_range(0, 23)), 20'd0, 20'($urandom_range(1, 4000)));
    if (pick < 92)
      return set_word(8'($urandom()), 20'($urandom_range(0, 3)), 20'($urandom()));
    return set_word(8'($urandom()), 20'($urandom()), 20'($urandom()));
  endfunction

  initial begin
    mtq_pkg::in_word_t w;
    sb = new();
    sb.clear();
    sb.n_errors = 0;
    sb.n_checked = 0;
    sb.n_expired = 0;
    sb.n_full = 0;
    n_sent = 0;
    stall_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored zero, add, reschedule, cancel, empty tick
    send_word(set_word(8'd7, 20'd0, 20'd0));
    send_word(set_word(8'd7, 20'd0, 20'd500));
    send_word(set_word(8'd7, 20'd0, 20'd200));
    send_word(set_word(8'd7, 20'd0, 20'd0));
    send_word(tick_word(32'd0));
    // fill to full with ties, plus extreme fields, then overflow
    send_word(set_word(8'd255, 20'hFFFFF, 20'hFFFFF));
    for (int i = 0; i < mtq_pkg::MAX_TIMERS - 1; i++)
      send_word(set_word(8'(i), 20'd0, (i < 8) ? 20'd100 : 20'd50));
    send_word(set_word(8'd200, 20'd1, 20'd0));
    // ticks covering many entries at once; the extreme-field entry outlasts them
    send_word(tick_word(32'hFFFFFFFF));
    send_word(tick_word(32'd1));
    send_word(tick_word(32'hFFFFFFFF));
    send_word(tick_word(32'hFFFFFFFF));

    // random part in bursts, receiver stalls switched on and off at random
    stall_on = 1'b1;
    while (n_sent < 355) begin
      if ($urandom_range(0, 7) == 0) stall_on = ~stall_on;
      repeat ($urandom_range(1, 12)) begin
        w = rand_word();
        send_word(w);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 25));
    end
    in_valid <= 1'b0;
    stall_on = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d expirations, %0d full rejections",
             n_sent, sb.n_checked, sb.n_expired, sb.n_full);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
